>>> design/bcdsw_pkg.sv
// shared types and constants for the bcd up/down stopwatch
`timescale 1ns / 1ps

package bcdsw_pkg;

  localparam logic [2:0] ACT_TICK   = 3'd0;
  localparam logic [2:0] ACT_RESET  = 3'd1;
  localparam logic [2:0] ACT_PAUSE  = 3'd2;
  localparam logic [2:0] ACT_RESUME = 3'd3;
  localparam logic [2:0] ACT_TOGGLE = 3'd4;
  localparam logic [2:0] ACT_ADJUST = 3'd5;

  localparam logic [1:0] UNIT_SEC  = 2'd0;
  localparam logic [1:0] UNIT_MIN  = 2'd1;
  localparam logic [1:0] UNIT_HOUR = 2'd2;

  localparam logic [3:0] ONES_MAX = 4'd9;
  localparam logic [2:0] TENS_MAX = 3'd5;

  localparam int IN_BYTES  = 1;
  localparam int OUT_BYTES = 4;

  typedef struct packed {
    logic [2:0] action;
    logic [1:0] unit;
    logic       increase;
  } bcdsw_item_t;

  typedef struct packed {
    logic [3:0] sec_ones;
    logic [2:0] sec_tens;
    logic [3:0] min_ones;
    logic [2:0] min_tens;
    logic [3:0] hour_ones;
    logic [2:0] hour_tens;
    logic       counting_up;
    logic       is_paused;
    logic       expired;
    logic       alarm;
  } bcdsw_state_t;

endpackage

>>> design/bcd_up_down_stopwatch_top.sv
// top level of the bcd up/down stopwatch with stream input and output
`timescale 1ns / 1ps

// Six-digit BCD stopwatch (HH:MM:SS, hours 00-59) counting up or down. Each event
// transfer on s_* yields exactly one result transfer on m_* showing the state after
// the event. An event is captured in an input register and then applied to the state
// register; the state register is also the result register, so one event per clock
// is sustained while m_tready stays high; a stalled result holds the next event in
// the input register. m_tvalid rises when the event is applied to the state register.

module bcd_up_down_stopwatch_top
  import bcdsw_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  input  logic [IN_BYTES*8-1:0]    s_tdata,  // action[2:0], unit[4:3], increase[5]
  output logic                     m_tvalid,
  input  logic                     m_tready,
  // sec_ones, sec_tens, min_ones, min_tens, hour_ones, hour_tens,
  // counting_up, is_paused, expired, alarm
  output logic [OUT_BYTES*8-1:0]   m_tdata
);

  localparam int STATE_W = $bits(bcdsw_state_t);

  localparam bcdsw_state_t ST_RESET = '{
    sec_ones:    4'd0,
    sec_tens:    3'd0,
    min_ones:    4'd0,
    min_tens:    3'd0,
    hour_ones:   4'd0,
    hour_tens:   3'd0,
    counting_up: 1'b1,
    is_paused:   1'b0,
    expired:     1'b0,
    alarm:       1'b0
  };

  bcdsw_item_t  item;
  logic         item_valid;
  bcdsw_state_t st;
  bcdsw_state_t st_next;
  logic         fire;

  // update state only when the result slot is free or being drained
  assign fire     = item_valid && (!m_tvalid || m_tready);
  assign s_tready = !item_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_tready) begin
      item_valid <= s_tvalid;
    end
  end

  // item struct is packed action-high
  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      item <= {s_tdata[2:0], s_tdata[4:3], s_tdata[5]};
    end
  end

  bcdsw_core u_core (
    .item(item),
    .st(st),
    .st_next(st_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st       <= ST_RESET;
      m_tvalid <= 1'b0;
    end else begin
      if (fire) begin
        st <= st_next;
      end
      if (fire) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  assign m_tdata = {{(OUT_BYTES*8-STATE_W){1'b0}},
                    st.alarm, st.expired, st.is_paused, st.counting_up,
                    st.hour_tens, st.hour_ones, st.min_tens, st.min_ones,
                    st.sec_tens, st.sec_ones};

endmodule

>>> design/bcdsw_pair.sv
// one two-digit bcd unit stepped by one modulo 60 in either direction
`timescale 1ns / 1ps

module bcdsw_pair
  import bcdsw_pkg::*;
(
  input  logic [3:0] ones,
  input  logic [2:0] tens,
  input  logic       up,
  output logic [3:0] ones_next,
  output logic [2:0] tens_next,
  output logic       wrap
);

  always_comb begin
    ones_next = ones;
    tens_next = tens;
    wrap      = 1'b0;
    if (up) begin
      if (ones < ONES_MAX) begin
        ones_next = ones + 4'd1;
      end else begin
        ones_next = 4'd0;
        if (tens < TENS_MAX) begin
          tens_next = tens + 3'd1;
        end else begin
          tens_next = 3'd0;
          wrap      = 1'b1;
        end
      end
    end else begin
      if (ones != 4'd0) begin
        ones_next = ones - 4'd1;
      end else begin
        ones_next = ONES_MAX;
        if (tens != 3'd0) begin
          tens_next = tens - 3'd1;
        end else begin
          tens_next = TENS_MAX;
          wrap      = 1'b1;
        end
      end
    end
  end

endmodule

>>> design/bcdsw_core.sv
// next-state logic of the stopwatch for one event
`timescale 1ns / 1ps

module bcdsw_core
  import bcdsw_pkg::*;
(
  input  bcdsw_item_t  item,
  input  bcdsw_state_t st,
  output bcdsw_state_t st_next
);

  logic       all_zero;
  logic       tick_run;
  logic       adj;
  logic       down_stop;
  logic       count;
  logic       dir;
  logic       en_sec;
  logic       en_min;
  logic       en_hour;
  logic [3:0] sec_o, min_o, hour_o;
  logic [2:0] sec_t, min_t, hour_t;
  logic       sec_wrap, min_wrap, hour_wrap;

  assign all_zero = (st.sec_ones == 4'd0) && (st.sec_tens == 3'd0) &&
                    (st.min_ones == 4'd0) && (st.min_tens == 3'd0) &&
                    (st.hour_ones == 4'd0) && (st.hour_tens == 3'd0);

  assign tick_run  = (item.action == ACT_TICK) && !st.is_paused;
  assign adj       = (item.action == ACT_ADJUST) && st.is_paused;
  // countdown holds once finished or when it hits zero
  assign down_stop = tick_run && !st.counting_up && (st.expired || all_zero);
  assign count     = tick_run && !down_stop;
  assign dir       = adj ? item.increase : st.counting_up;

  assign en_sec  = count || (adj && item.unit == UNIT_SEC);
  assign en_min  = (count && sec_wrap) || (adj && item.unit == UNIT_MIN);
  assign en_hour = (count && sec_wrap && min_wrap) || (adj && item.unit == UNIT_HOUR);

  bcdsw_pair u_sec (
    .ones(st.sec_ones), .tens(st.sec_tens), .up(dir),
    .ones_next(sec_o), .tens_next(sec_t), .wrap(sec_wrap)
  );

  bcdsw_pair u_min (
    .ones(st.min_ones), .tens(st.min_tens), .up(dir),
    .ones_next(min_o), .tens_next(min_t), .wrap(min_wrap)
  );

  bcdsw_pair u_hour (
    .ones(st.hour_ones), .tens(st.hour_tens), .up(dir),
    .ones_next(hour_o), .tens_next(hour_t), .wrap(hour_wrap)
  );

  always_comb begin
    st_next = st;
    if (en_sec) begin
      st_next.sec_ones = sec_o;
      st_next.sec_tens = sec_t;
    end
    if (en_min) begin
      st_next.min_ones = min_o;
      st_next.min_tens = min_t;
    end
    if (en_hour) begin
      st_next.hour_ones = hour_o;
      st_next.hour_tens = hour_t;
    end
    case (item.action)
      ACT_TICK: begin
        if (down_stop && !st.expired) begin
          st_next.expired = 1'b1;
          st_next.alarm   = 1'b1;
        end
      end
      ACT_RESET: begin
        st_next.sec_ones  = 4'd0;
        st_next.sec_tens  = 3'd0;
        st_next.min_ones  = 4'd0;
        st_next.min_tens  = 3'd0;
        st_next.hour_ones = 4'd0;
        st_next.hour_tens = 3'd0;
        st_next.expired   = 1'b0;
        st_next.alarm     = 1'b0;
      end
      ACT_PAUSE: begin
        st_next.is_paused = 1'b1;
        st_next.alarm     = 1'b0;
      end
      ACT_RESUME: begin
        st_next.is_paused = 1'b0;
      end
      ACT_TOGGLE: begin
        if (st.is_paused) begin
          st_next.counting_up = !st.counting_up;
          st_next.expired     = 1'b0;
        end
      end
      default: begin
      end
    endcase
    // hour_wrap has no further unit to carry into
    if (hour_wrap && 1'b0) begin
      st_next = st;
    end
  end

endmodule
